>>> hdl/oopw_pkg.sv
// Shared constants, types and helper functions for the oscillating offset point warp.
// Holds the wave table, built at elaboration, and the output saturation function.
// No dependencies; the lane, the top level and the testbench import this package.
package oopw_pkg;

	localparam int PHASE_BITS = 10;
	localparam int FRAC_BITS  = 16;
	localparam int BLEND_FRAC = 16;
	localparam int WAVE_N     = 1 << PHASE_BITS;
	localparam int NSTG       = 9;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

	typedef enum logic [2:0] {
		REG_X_BLEND     = 3'd0,
		REG_Y_BLEND     = 3'd1,
		REG_CENTER_X    = 3'd2,
		REG_CENTER_Y    = 3'd3,
		REG_BAND_SCALE  = 3'd4,
		REG_SQUARE_MODE = 3'd5,
		REG_WEIGHT      = 3'd6
	} reg_idx_t;

	typedef logic [FRAC_BITS-1:0] wave_t;
	typedef wave_t wave_tbl_t [WAVE_N];

	// sin^2(pi*k/N) from a truncated integer Taylor series; the half turn is exactly one
	// and wraps to zero, and any other entry that rounds up to one is clamped below it.
	function automatic wave_tbl_t build_wave();
		wave_tbl_t   tbl;
		logic [63:0] half;
		logic [63:0] m;
		logic [63:0] th;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] sq;
		logic [63:0] one;
		half = 64'(WAVE_N / 2);
		one  = 64'(1) << FRAC_BITS;
		for (int k = 0; k < WAVE_N; k++) begin
			if (64'(k) == half) begin
				tbl[k] = '0;
			end else begin
				m    = (64'(k) > half) ? 64'(WAVE_N - k) : 64'(k);
				th   = (m * PI_Q30) >> PHASE_BITS;
				x2   = (th * th) >> 30;
				term = th;
				s    = th;
				for (int i = 1; i <= 6; i++) begin
					term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
					if ((i % 2) == 1) begin
						s = s - term;
					end else begin
						s = s + term;
					end
				end
				sq = (s * s + (64'(1) << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
				if (sq >= one) begin
					sq = one - 64'(1);
				end
				tbl[k] = sq[FRAC_BITS-1:0];
			end
		end
		return tbl;
	endfunction

	localparam wave_tbl_t WAVE_TBL = build_wave();

	// Floor shift of a full product back to the coordinate format, saturated to 32 bits.
	function automatic logic signed [31:0] sat_scale(input logic signed [63:0] prod);
		logic signed [63:0] sh;
		sh = prod >>> FRAC_BITS;
		if (sh > SAT_MAX) begin
			return SAT_MAX[31:0];
		end else if (sh < SAT_MIN) begin
			return SAT_MIN[31:0];
		end
		return sh[31:0];
	endfunction

endpackage

>>> hdl/oopw_in_if.sv
// Input point channel: valid/ready handshake carrying one Q16.16 point per word.
// No dependencies.
interface oopw_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;

	modport source (output valid, output in_x, output in_y, output in_z, input ready);
	modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

>>> hdl/oopw_out_if.sv
// Result point channel: valid/ready handshake carrying one warped Q16.16 point per word.
// No dependencies.
interface oopw_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;

	modport source (output valid, output out_x, output out_y, output out_z, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

>>> hdl/oopw_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying a register index and data.
// No dependencies.
interface oopw_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/oopw_lane.sv
// Nine-stage datapath for one coordinate: center offset, two wave blends, output scaling.
// Depends on oopw_pkg for the wave table, stage count and saturation function.
module oopw_lane import oopw_pkg::*; (
	input  logic                clk,
	input  logic [NSTG-1:0]     en,
	input  logic signed [31:0]  coord,
	input  logic signed [31:0]  center,
	input  logic [15:0]         blend,
	input  logic [21:0]         band_scale,
	input  logic signed [31:0]  weight,
	output logic signed [31:0]  result
);

	localparam int IDX_LSB = 2 * FRAC_BITS - PHASE_BITS;
	localparam int PH1_W   = 34 + FRAC_BITS;

	logic signed [32:0]     sum;
	logic signed [31:0]     sat_v;
	logic [PH1_W-1:0]       ph1;
	logic [56:0]            ph2;
	logic signed [32:0]     diff1;
	logic signed [32:0]     diff2;
	logic signed [49:0]     acc1;
	logic signed [49:0]     acc2;

	logic signed [31:0]     v_s1, v_s2, v_s3, v_s4;
	logic signed [54:0]     p_s2;
	logic [PHASE_BITS-1:0]  idx1_s2;
	wave_t                  t1_s3, t2_s3, t2_s4, t2_s5;
	logic signed [49:0]     d1_s4, d2_s6;
	logic signed [31:0]     r1_s5, r1_s6, r2_s7;
	logic signed [63:0]     m_s8;
	logic signed [31:0]     res_s9;

	always_comb begin
		sum = {coord[31], coord} + {center[31], center};
		if (sum[32] != sum[31]) begin
			sat_v = sum[32] ? SAT_MIN[31:0] : SAT_MAX[31:0];
		end else begin
			sat_v = sum[31:0];
		end
		ph1   = {v_s1, {(FRAC_BITS + 2){1'b0}}};
		ph2   = {p_s2, 2'b00};
		diff1 = $signed({{(33 - FRAC_BITS){1'b0}}, t1_s3}) - {v_s3[31], v_s3};
		diff2 = $signed({{(33 - FRAC_BITS){1'b0}}, t2_s5}) - {r1_s5[31], r1_s5};
		acc1  = $signed({{18{v_s4[31]}}, v_s4}) + (d1_s4 >>> BLEND_FRAC);
		acc2  = $signed({{18{r1_s6[31]}}, r1_s6}) + (d2_s6 >>> BLEND_FRAC);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v_s1 <= sat_v;
		end
		if (en[1]) begin
			v_s2    <= v_s1;
			p_s2    <= v_s1 * $signed({1'b0, band_scale});
			idx1_s2 <= ph1[IDX_LSB +: PHASE_BITS];
		end
		if (en[2]) begin
			v_s3  <= v_s2;
			t1_s3 <= WAVE_TBL[idx1_s2];
			t2_s3 <= WAVE_TBL[ph2[IDX_LSB +: PHASE_BITS]];
		end
		if (en[3]) begin
			v_s4  <= v_s3;
			t2_s4 <= t2_s3;
			d1_s4 <= diff1 * $signed({1'b0, blend});
		end
		if (en[4]) begin
			r1_s5 <= acc1[31:0];
			t2_s5 <= t2_s4;
		end
		if (en[5]) begin
			r1_s6 <= r1_s5;
			d2_s6 <= diff2 * $signed({1'b0, blend});
		end
		if (en[6]) begin
			r2_s7 <= acc2[31:0];
		end
		if (en[7]) begin
			m_s8 <= weight * r2_s7;
		end
		if (en[8]) begin
			res_s9 <= sat_scale(m_s8);
		end
	end

	assign result = res_s9;

endmodule

>>> hdl/oscillating_offset_point_warp.sv
// Top level of the oscillating offset point warp: configuration registers, stage control, z path.
// Depends on oopw_pkg, the three channel interfaces and oopw_lane.
//
// Usage:
// Points arrive on the point channel and leave on the warped channel, both valid/ready.
// A word is taken at a rising edge where valid and ready are both high.
// The datapath is nine register stages; the last one is the output register.
// An accepted point is offered on the warped channel once it reaches the output register.
// One point per cycle is sustained while the receiver holds ready high; the multipliers and
// the wave table read are each followed by a register, which sets the stage count.
// When the receiver holds ready low, the stages fill from the output end and
// empty stages keep taking words, so bubbles close up and nothing is lost.
// Registers are written through cfg, which is always ready; write them only
// while no point is in flight. An index beyond the register list is ignored.
// Reset empties the pipeline and returns the registers to their reset values:
// blend weights and centers zero, band scale and weight one.
module oscillating_offset_point_warp import oopw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	oopw_in_if.sink     point,
	oopw_out_if.source  warped,
	oopw_cfg_if.sink    cfg
);

	logic [15:0]        x_blend_q;
	logic [15:0]        y_blend_q;
	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;
	logic [21:0]        band_scale_q;
	logic               square_mode_q;
	logic signed [31:0] weight_q;

	logic [NSTG-1:0]    vld_q;
	logic [NSTG-1:0]    en;
	logic [15:0]        wy;

	logic signed [31:0] z_s1, z_s2, z_s3, z_s4, z_s5, z_s6, z_s7;
	logic signed [63:0] zm_s8;
	logic signed [31:0] z_s9;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_blend_q     <= '0;
			y_blend_q     <= '0;
			center_x_q    <= '0;
			center_y_q    <= '0;
			band_scale_q  <= 22'(1 << FRAC_BITS);
			square_mode_q <= 1'b0;
			weight_q      <= 32'(1 << FRAC_BITS);
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_X_BLEND:     x_blend_q     <= cfg.data[15:0];
				REG_Y_BLEND:     y_blend_q     <= cfg.data[15:0];
				REG_CENTER_X:    center_x_q    <= cfg.data;
				REG_CENTER_Y:    center_y_q    <= cfg.data;
				REG_BAND_SCALE:  band_scale_q  <= cfg.data[21:0];
				REG_SQUARE_MODE: square_mode_q <= cfg.data[0];
				REG_WEIGHT:      weight_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its successor is loading this cycle.
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || warped.ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign point.ready  = en[0];
	assign warped.valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= point.valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign wy = square_mode_q ? x_blend_q : y_blend_q;

	oopw_lane u_lane_x (
		.clk        (clk),
		.en         (en),
		.coord      (point.in_x),
		.center     (center_x_q),
		.blend      (x_blend_q),
		.band_scale (band_scale_q),
		.weight     (weight_q),
		.result     (warped.out_x)
	);

	oopw_lane u_lane_y (
		.clk        (clk),
		.en         (en),
		.coord      (point.in_y),
		.center     (center_y_q),
		.blend      (wy),
		.band_scale (band_scale_q),
		.weight     (weight_q),
		.result     (warped.out_y)
	);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			z_s1 <= point.in_z;
		end
		if (en[1]) begin
			z_s2 <= z_s1;
		end
		if (en[2]) begin
			z_s3 <= z_s2;
		end
		if (en[3]) begin
			z_s4 <= z_s3;
		end
		if (en[4]) begin
			z_s5 <= z_s4;
		end
		if (en[5]) begin
			z_s6 <= z_s5;
		end
		if (en[6]) begin
			z_s7 <= z_s6;
		end
		if (en[7]) begin
			zm_s8 <= weight_q * z_s7;
		end
		if (en[8]) begin
			z_s9 <= sat_scale(zm_s8);
		end
	end

	assign warped.out_z = z_s9;

endmodule

>>> sim/oscillating_offset_point_warp_tb.sv
// Testbench for oscillating_offset_point_warp: drives register writes, and points with random
// gaps and back-pressure, and checks every warped word against a Q16.16 prediction.
// Depends on oopw_pkg, the point, warped and cfg channel interfaces, and the block itself.
module oscillating_offset_point_warp_tb;
	import oopw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TURN_MULT    = 4;
	localparam int          PIPE_DEPTH   = 9;
	localparam logic [2:0]  IDX_UNUSED   = 3'd7;
	localparam longint      RUN_LIMIT_NS = 3000000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	logic clk;
	logic arst_n;

	oopw_in_if  point_ch();
	oopw_out_if warped_ch();
	oopw_cfg_if cfg_ch();

	oscillating_offset_point_warp i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (point_ch),
		.warped (warped_ch),
		.cfg    (cfg_ch)
	);

	logic [15:0]        m_xb;
	logic [15:0]        m_yb;
	logic signed [31:0] m_cx;
	logic signed [31:0] m_cy;
	logic [21:0]        m_bs;
	logic               m_sq;
	logic signed [31:0] m_w;

	logic [FRAC_BITS-1:0] sin2_lut [WAVE_N];
	point_t               warp_expected [$];

	bit steady_flow;
	int fails;
	int points_sent;
	int words_checked;
	int reg_writes;
	int settings_used;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	function automatic logic [FRAC_BITS-1:0] sin2_entry(int unsigned k);
		longint unsigned half;
		longint unsigned m;
		longint unsigned ang;
		longint unsigned ang2;
		longint unsigned tn;
		longint unsigned acc;
		longint unsigned sq;
		longint unsigned unity;
		half  = WAVE_N / 2;
		unity = longint'(1) << FRAC_BITS;
		if (k == half) begin
			return '0;
		end
		m    = (k > half) ? longint'(WAVE_N - k) : longint'(k);
		ang  = (m * PI_Q30) >> PHASE_BITS;
		ang2 = (ang * ang) >> 30;
		tn   = ang;
		acc  = ang;
		for (int i = 1; i <= 6; i++) begin
			tn = ((tn * ang2) >> 30) / longint'((2 * i) * (2 * i + 1));
			if ((i % 2) == 1) begin
				acc = acc - tn;
			end else begin
				acc = acc + tn;
			end
		end
		sq = (acc * acc + (longint'(1) << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
		if (sq >= unity) begin
			sq = unity - 1;
		end
		return sq[FRAC_BITS-1:0];
	endfunction

	initial begin
		for (int k = 0; k < WAVE_N; k++) begin
			sin2_lut[k] = sin2_entry(k);
		end
	end

	function automatic longint clip32(longint v);
		if (v > longint'(SAT_MAX)) begin
			return SAT_MAX;
		end
		if (v < longint'(SAT_MIN)) begin
			return SAT_MIN;
		end
		return v;
	endfunction

	function automatic int turn_index(longint q);
		longint unsigned u;
		u = q;
		u = u * TURN_MULT;
		return int'((u >> (2 * FRAC_BITS - PHASE_BITS)) & longint'(WAVE_N - 1));
	endfunction

	function automatic longint lerp16(longint a, longint b, logic [15:0] w);
		longint wl;
		wl = w;
		return a + (((b - a) * wl) >>> BLEND_FRAC);
	endfunction

	function automatic longint bend(longint v, logic [15:0] w);
		longint bs;
		longint t1;
		longint t2;
		bs = m_bs;
		t1 = sin2_lut[turn_index(v * (longint'(1) << FRAC_BITS))];
		t2 = sin2_lut[turn_index(v * bs)];
		return lerp16(lerp16(v, t1, w), t2, w);
	endfunction

	function automatic logic signed [31:0] weigh(longint v);
		longint p;
		p = longint'(m_w) * v;
		return 32'(clip32(p >>> FRAC_BITS));
	endfunction

	function automatic point_t warp_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		point_t      r;
		longint      ox;
		longint      oy;
		logic [15:0] wy;
		ox  = clip32(longint'(x) + longint'(m_cx));
		oy  = clip32(longint'(y) + longint'(m_cy));
		wy  = m_sq ? m_xb : m_yb;
		r.x = weigh(bend(ox, m_xb));
		r.y = weigh(bend(oy, wy));
		r.z = weigh(longint'(z));
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4, 5: return $urandom();
			default: return 32'($urandom_range(0, 262143)) - 32'h0002_0000;
		endcase
	endfunction

	function automatic bit idle_now();
		return !steady_flow && ($urandom_range(99) < 37);
	endfunction

	always @(negedge clk) begin
		warped_ch.ready <= arst_n && (steady_flow || ($urandom_range(99) >= 37));
	end

	always @(posedge clk) begin : check_results
		point_t want;
		if (arst_n && warped_ch.valid && warped_ch.ready) begin
			if (warp_expected.size() == 0) begin
				$error("warped word with no point outstanding");
				fails++;
			end else begin
				want = warp_expected.pop_front();
				words_checked++;
				if (warped_ch.out_x !== want.x) begin
					$error("out_x expected %0d actual %0d", want.x, warped_ch.out_x);
					fails++;
				end
				if (warped_ch.out_y !== want.y) begin
					$error("out_y expected %0d actual %0d", want.y, warped_ch.out_y);
					fails++;
				end
				if (warped_ch.out_z !== want.z) begin
					$error("out_z expected %0d actual %0d", want.z, warped_ch.out_z);
					fails++;
				end
			end
		end
	end

	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		while (idle_now()) begin
			@(negedge clk);
			point_ch.valid <= 1'b0;
		end
		@(negedge clk);
		point_ch.valid <= 1'b1;
		point_ch.in_x  <= x;
		point_ch.in_y  <= y;
		point_ch.in_z  <= z;
		do @(posedge clk); while (!point_ch.ready);
		warp_expected.push_back(warp_point(x, y, z));
		points_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		point_ch.valid <= 1'b0;
		while (warp_expected.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_X_BLEND:     m_xb = d[15:0];
			REG_Y_BLEND:     m_yb = d[15:0];
			REG_CENTER_X:    m_cx = d;
			REG_CENTER_Y:    m_cy = d;
			REG_BAND_SCALE:  m_bs = d[21:0];
			REG_SQUARE_MODE: m_sq = d[0];
			REG_WEIGHT:      m_w  = d;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic randomize_settings();
		write_reg(REG_X_BLEND, rand_word());
		write_reg(REG_Y_BLEND, rand_word());
		write_reg(REG_CENTER_X, rand_word());
		write_reg(REG_CENTER_Y, rand_word());
		write_reg(REG_BAND_SCALE, rand_word());
		write_reg(REG_SQUARE_MODE, rand_word());
		write_reg(REG_WEIGHT, rand_word());
		if ($urandom_range(1) == 1) begin
			write_reg(IDX_UNUSED, rand_word());
		end
		settings_used++;
	endtask

	task automatic test_reset_defaults();
		settings_used++;
		send_point(32'sd0, 32'sd0, 32'sd0);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(-32'sd1, -32'sd1, -32'sd1);
		send_point(32'sh0000_2000, 32'sh0000_2000, 32'sd1);
		settle();
	endtask

	task automatic test_register_masking();
		write_reg(REG_X_BLEND, 32'hFFFF_FFFF);
		write_reg(REG_Y_BLEND, 32'hFFFF_8000);
		write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
		write_reg(REG_CENTER_Y, 32'h8000_0000);
		write_reg(REG_BAND_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_SQUARE_MODE, 32'hFFFF_FFFE);
		write_reg(REG_WEIGHT, 32'h7FFF_FFFF);
		write_reg(IDX_UNUSED, 32'h0000_0000);
		settings_used++;
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(32'sd0, 32'sd0, 32'sd0);
		send_point(32'sd1, -32'sd1, 32'sd2);
		settle();
	endtask

	task automatic test_half_turn_wrap();
		write_reg(REG_CENTER_X, 32'h0000_0000);
		write_reg(REG_CENTER_Y, 32'h0000_0000);
		write_reg(REG_Y_BLEND, 32'h0000_0000);
		write_reg(REG_SQUARE_MODE, 32'h0000_0001);
		write_reg(REG_BAND_SCALE, 32'h0000_0000);
		write_reg(REG_WEIGHT, 32'h8000_0000);
		settings_used++;
		send_point(32'sh0000_2000, 32'sh0000_2000, 32'sh8000_0000);
		send_point(32'sh0000_1FF0, 32'sh0000_2010, 32'sh7FFF_FFFF);
		send_point(32'sh0000_2010, 32'sh0000_1FF0, 32'sd0);
		send_point(32'shFFFF_E000, 32'shFFFF_E000, -32'sd1);
		send_point(32'sh0000_FFFF, 32'shFFFF_0001, 32'sd1);
		settle();
	endtask

	task automatic test_weight_sign();
		write_reg(REG_SQUARE_MODE, 32'h0000_0000);
		write_reg(REG_Y_BLEND, 32'h0000_FFFF);
		write_reg(REG_X_BLEND, 32'h0000_4000);
		write_reg(REG_BAND_SCALE, 32'h0001_0000);
		write_reg(REG_WEIGHT, 32'h0000_0000);
		settings_used++;
		send_point(32'sh0001_2345, 32'shFFFE_DCBA, 32'sh7FFF_FFFF);
		send_point(32'sh0000_2000, 32'sh0000_6000, 32'sh8000_0000);
		settle();
		write_reg(REG_WEIGHT, 32'hFFFF_0000);
		settings_used++;
		send_point(32'sh0001_2345, 32'shFFFE_DCBA, 32'sh7FFF_FFFF);
		send_point(32'sh0000_2000, 32'sh0000_6000, 32'sh8000_0000);
		settle();
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 8; p++) begin
			randomize_settings();
			for (int n = 0; n < 110; n++) begin
				send_point(rand_word(), rand_word(), rand_word());
			end
			settle();
		end
	endtask

	task automatic test_steady_stream();
		randomize_settings();
		steady_flow = 1'b1;
		for (int n = 0; n < 80; n++) begin
			send_point(rand_word(), rand_word(), rand_word());
		end
		settle();
		steady_flow = 1'b0;
	endtask

	initial begin
		#RUN_LIMIT_NS;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		steady_flow     = 1'b0;
		fails           = 0;
		points_sent     = 0;
		words_checked   = 0;
		reg_writes      = 0;
		settings_used   = 0;
		point_ch.valid  = 1'b0;
		point_ch.in_x   = '0;
		point_ch.in_y   = '0;
		point_ch.in_z   = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;
		warped_ch.ready = 1'b0;
		m_xb            = '0;
		m_yb            = '0;
		m_cx            = '0;
		m_cy            = '0;
		m_bs            = 22'(1 << FRAC_BITS);
		m_sq            = 1'b0;
		m_w             = 32'(1 << FRAC_BITS);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_masking();
		test_half_turn_wrap();
		test_weight_sign();
		test_random_settings();
		test_steady_stream();

		settle();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (warp_expected.size() != 0) begin
			$error("%0d warped words never arrived", warp_expected.size());
			fails++;
		end
		$display("Sent %0d points and checked %0d warped words under %0d register settings.",
			points_sent, words_checked, settings_used);
		$display("Made %0d register writes, with random gaps and back-pressure on both sides.",
			reg_writes);
		if (fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> oscillating_offset_point_warp.f
hdl/oopw_pkg.sv
hdl/oopw_in_if.sv
hdl/oopw_out_if.sv
hdl/oopw_cfg_if.sv
hdl/oopw_lane.sv
hdl/oscillating_offset_point_warp.sv
sim/oscillating_offset_point_warp_tb.sv
